// ----- rtl/pfm_pkg.sv -----
// ----------------------------------------------------------------------------
// pfm_pkg
// shared types, constants and helpers of the paged frame manager
// ----------------------------------------------------------------------------
package pfm_pkg;

  localparam int NUM_FRAMES = 16;
  localparam int FIDX_W     = (NUM_FRAMES > 1) ? $clog2(NUM_FRAMES) : 1;
  localparam int CNT_W      = $clog2(NUM_FRAMES + 1);
  localparam int CFG_W      = 9;
  localparam int CFG_IDX_W  = 2;

  localparam logic [CFG_IDX_W-1:0] CFG_POLICY    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_PAGE_LOG2 = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_FRAMES    = 2'd2;

  localparam logic       POLICY_FIFO    = 1'b0;
  localparam logic       POLICY_LRU     = 1'b1;
  localparam logic       FUNC_ACCESS    = 1'b0;
  localparam logic       FUNC_RELEASE   = 1'b1;
  localparam logic [4:0] LG_MIN         = 5'd4;
  localparam logic [4:0] LG_MAX         = 5'd16;
  localparam logic [4:0] LG_RESET       = 5'd8;
  localparam logic [8:0] FRAMES_RESET   = 9'd16;

  typedef struct packed {
    logic        func;
    logic [7:0]  pid;
    logic [27:0] page;
    logic [15:0] offset;
  } item_t;

  typedef struct packed {
    logic             idle;
    logic [CNT_W-1:0] order_cnt;
    logic [CNT_W-1:0] resident_cnt;
  } bk_status_t;

  function automatic logic [4:0] clamp_lg(input logic [4:0] v);
    logic [4:0] r;
    r = v;
    if (v < LG_MIN) r = LG_MIN;
    if (v > LG_MAX) r = LG_MAX;
    return r;
  endfunction

  function automatic logic [CNT_W-1:0] clamp_limit(input logic [8:0] v);
    logic [CNT_W-1:0] r;
    if (v == 9'd0) r = CNT_W'(1);
    else if (v > 9'(NUM_FRAMES)) r = CNT_W'(NUM_FRAMES);
    else r = v[CNT_W-1:0];
    return r;
  endfunction

endpackage

// ----- rtl/pfm_front.sv -----
// ----------------------------------------------------------------------------
// pfm_front
// accepts beats, splits the address into page and offset, two-entry queue
// ----------------------------------------------------------------------------
module pfm_front (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic              in_func,
  input  logic [7:0]        in_pid,
  input  logic [31:0]       in_logical_address,
  input  logic [4:0]        lg,
  output logic              q_valid,
  output pfm_pkg::item_t    q_item,
  input  logic              q_pop
);
  import pfm_pkg::*;

  item_t       q_r [2];
  logic        wp_r, rp_r;
  logic [1:0]  cnt_r;
  logic [4:0]  lgc;
  logic [31:0] page_full;
  logic [31:0] off_full;
  item_t       new_item;
  logic        push;

  assign lgc       = clamp_lg(lg);
  assign page_full = in_logical_address >> lgc;
  assign off_full  = in_logical_address & ((32'd1 << lgc) - 32'd1);
  assign new_item  = '{func: in_func, pid: in_pid, page: page_full[27:0],
                       offset: off_full[15:0]};

  assign in_ready = (cnt_r != 2'd2);
  assign push     = in_valid && in_ready;
  assign q_valid  = (cnt_r != 2'd0);
  assign q_item   = q_r[rp_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (push) begin
        q_r[wp_r] <= new_item;
        wp_r      <= ~wp_r;
      end
      if (q_pop) rp_r <= ~rp_r;
      cnt_r <= cnt_r + {1'b0, push} - {1'b0, q_pop};
    end
  end

endmodule

// ----- rtl/pfm_back.sv -----
// ----------------------------------------------------------------------------
// pfm_back
// frame table sequencer: lookup and release scans, eviction, order compaction, result beat
// ----------------------------------------------------------------------------
module pfm_back (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                q_valid,
  input  pfm_pkg::item_t      q_item,
  output logic                q_pop,
  input  logic                policy,
  input  logic [4:0]          lg,
  input  logic [8:0]          frames_in_use,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [23:0]         out_physical_address,
  output logic [7:0]          out_frame_index,
  output logic                out_page_fault,
  output logic                out_evicted,
  output logic [7:0]          out_victim_pid,
  output logic [27:0]         out_victim_page,
  output logic [8:0]          out_released_count,
  output pfm_pkg::bk_status_t status
);
  import pfm_pkg::*;

  typedef enum logic [2:0] {S_IDLE, S_SCAN, S_RSCAN, S_VICT, S_COMP, S_FIN} state_t;

  state_t             state_r;
  item_t              it_r;
  logic [NUM_FRAMES-1:0] valid_r;
  logic [7:0]         owner_r [NUM_FRAMES];
  logic [27:0]        page_r  [NUM_FRAMES];
  logic [FIDX_W-1:0]  order_r [NUM_FRAMES];
  logic [CNT_W-1:0]   ocnt_r;
  logic [FIDX_W-1:0]  f_r, frame_r, rm_r, free_r;
  logic               free_found_r, fault_r, evict_r, append_r;
  logic [CNT_W-1:0]   r_r, w_r, rel_r;
  logic [7:0]         vpid_r;
  logic [27:0]        vpage_r;
  logic               out_valid_r;
  logic [23:0]        out_pa_r;
  logic [7:0]         out_fi_r, out_vpid_r;
  logic               out_pf_r, out_ev_r;
  logic [27:0]        out_vpage_r;
  logic [8:0]         out_rel_r;

  logic [FIDX_W-1:0]  victim, rd_idx, comp_ol;
  logic [7:0]         owner_rd;
  logic [27:0]        page_rd;
  logic               match, free_now, keep, last_f, slot_free;
  logic [CNT_W-1:0]   limit;
  logic [4:0]         lgc;
  logic [31:0]        phys;

  assign victim   = order_r[0];
  assign rd_idx   = (state_r == S_VICT) ? victim : f_r;
  assign owner_rd = owner_r[rd_idx];
  assign page_rd  = page_r[rd_idx];
  assign limit    = clamp_limit(frames_in_use);
  assign lgc      = clamp_lg(lg);
  assign last_f   = (f_r == FIDX_W'(NUM_FRAMES - 1));
  assign match    = valid_r[f_r] && (owner_rd == it_r.pid) && (page_rd == it_r.page);
  assign free_now = !valid_r[f_r] && (CNT_W'(f_r) < limit);
  assign comp_ol  = order_r[r_r[FIDX_W-1:0]];
  assign keep     = (it_r.func == FUNC_RELEASE) ? valid_r[comp_ol] : (comp_ol != rm_r);
  assign slot_free = !out_valid_r || out_ready;
  assign phys     = (32'(frame_r) << lgc) + 32'(it_r.offset);
  assign q_pop    = (state_r == S_IDLE) && q_valid;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      valid_r     <= '0;
      ocnt_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if ((state_r == S_FIN) && slot_free) out_valid_r <= 1'b1;
      else if (out_ready) out_valid_r <= 1'b0;
      case (state_r)
        S_IDLE: begin
          if (q_valid) begin
            it_r         <= q_item;
            f_r          <= '0;
            rel_r        <= '0;
            free_found_r <= 1'b0;
            fault_r      <= 1'b0;
            evict_r      <= 1'b0;
            vpid_r       <= '0;
            vpage_r      <= '0;
            frame_r      <= '0;
            r_r          <= '0;
            w_r          <= '0;
            state_r      <= (q_item.func == FUNC_RELEASE) ? S_RSCAN : S_SCAN;
          end
        end
        S_SCAN: begin
          f_r <= f_r + FIDX_W'(1);
          if (match) begin
            frame_r  <= f_r;
            rm_r     <= f_r;
            append_r <= 1'b1;
            state_r  <= (policy == POLICY_LRU) ? S_COMP : S_FIN;
          end else begin
            if (free_now && !free_found_r) begin
              free_found_r <= 1'b1;
              free_r       <= f_r;
            end
            if (last_f) begin
              fault_r <= 1'b1;
              if (free_found_r || free_now) begin
                frame_r <= free_found_r ? free_r : f_r;
                valid_r[free_found_r ? free_r : f_r] <= 1'b1;
                owner_r[free_found_r ? free_r : f_r] <= it_r.pid;
                page_r[free_found_r ? free_r : f_r]  <= it_r.page;
                if (ocnt_r < CNT_W'(NUM_FRAMES)) begin
                  order_r[ocnt_r[FIDX_W-1:0]] <= free_found_r ? free_r : f_r;
                  ocnt_r <= ocnt_r + CNT_W'(1);
                end
                state_r <= S_FIN;
              end else if (ocnt_r != '0) begin
                state_r <= S_VICT;
              end else begin
                frame_r    <= '0;
                valid_r[0] <= 1'b1;
                owner_r[0] <= it_r.pid;
                page_r[0]  <= it_r.page;
                order_r[0] <= '0;
                ocnt_r     <= CNT_W'(1);
                state_r    <= S_FIN;
              end
            end
          end
        end
        S_VICT: begin
          evict_r         <= 1'b1;
          vpid_r          <= owner_rd;
          vpage_r         <= page_rd;
          frame_r         <= victim;
          rm_r            <= victim;
          append_r        <= 1'b1;
          owner_r[victim] <= it_r.pid;
          page_r[victim]  <= it_r.page;
          state_r         <= S_COMP;
        end
        S_RSCAN: begin
          f_r <= f_r + FIDX_W'(1);
          if (valid_r[f_r] && owner_rd == it_r.pid) begin
            valid_r[f_r] <= 1'b0;
            rel_r        <= rel_r + CNT_W'(1);
          end
          if (last_f) begin
            append_r <= 1'b0;
            state_r  <= S_COMP;
          end
        end
        S_COMP: begin
          if (r_r < ocnt_r) begin
            r_r <= r_r + CNT_W'(1);
            if (keep) begin
              order_r[w_r[FIDX_W-1:0]] <= comp_ol;
              w_r <= w_r + CNT_W'(1);
            end
          end else begin
            if (append_r && w_r < CNT_W'(NUM_FRAMES)) begin
              order_r[w_r[FIDX_W-1:0]] <= frame_r;
              ocnt_r <= w_r + CNT_W'(1);
            end else begin
              ocnt_r <= w_r;
            end
            state_r <= S_FIN;
          end
        end
        S_FIN: begin
          if (slot_free) begin
            if (it_r.func == FUNC_RELEASE) begin
              out_pa_r    <= '0;
              out_fi_r    <= '0;
              out_pf_r    <= 1'b0;
              out_ev_r    <= 1'b0;
              out_vpid_r  <= '0;
              out_vpage_r <= '0;
              out_rel_r   <= 9'(rel_r);
            end else begin
              out_pa_r    <= phys[23:0];
              out_fi_r    <= 8'(frame_r);
              out_pf_r    <= fault_r;
              out_ev_r    <= evict_r;
              out_vpid_r  <= vpid_r;
              out_vpage_r <= vpage_r;
              out_rel_r   <= '0;
            end
            state_r <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_valid            = out_valid_r;
  assign out_physical_address = out_pa_r;
  assign out_frame_index      = out_fi_r;
  assign out_page_fault       = out_pf_r;
  assign out_evicted          = out_ev_r;
  assign out_victim_pid       = out_vpid_r;
  assign out_victim_page      = out_vpage_r;
  assign out_released_count   = out_rel_r;

  assign status = '{idle: (state_r == S_IDLE), order_cnt: ocnt_r,
                    resident_cnt: CNT_W'($countones(valid_r))};

endmodule

// ----- rtl/paged_frame_manager_fifo_lru.sv -----
// ----------------------------------------------------------------------------
// paged_frame_manager_fifo_lru
// demand-paging frame manager with fifo or lru replacement
// ----------------------------------------------------------------------------
// an item runs the table scan, which checks one frame per cycle and stops early on a hit;
// an lru move, an eviction or a release then runs the order compaction, one entry per cycle
// the sequencer takes a new item only when done with the last; the front queue holds two beats
// reset: synchronous active low; all frames free, config to defaults
module paged_frame_manager_fifo_lru (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_we,
  input  logic [pfm_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [pfm_pkg::CFG_W-1:0]         cfg_data,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic                              in_func,
  input  logic [7:0]                        in_pid,
  input  logic [31:0]                       in_logical_address,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [23:0]                       out_physical_address,
  output logic [7:0]                        out_frame_index,
  output logic                              out_page_fault,
  output logic                              out_evicted,
  output logic [7:0]                        out_victim_pid,
  output logic [27:0]                       out_victim_page,
  output logic [8:0]                        out_released_count
);
  import pfm_pkg::*;

  logic       policy_r;
  logic [4:0] lg_r;
  logic [8:0] frames_r;
  logic       q_valid, q_pop;
  item_t      q_item;
  bk_status_t status;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      policy_r <= POLICY_FIFO;
      lg_r     <= LG_RESET;
      frames_r <= FRAMES_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_POLICY:    policy_r <= cfg_data[0];
        CFG_PAGE_LOG2: lg_r     <= cfg_data[4:0];
        CFG_FRAMES:    frames_r <= cfg_data[8:0];
        default: ;
      endcase
    end
  end

  pfm_front u_front (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .in_func            (in_func),
    .in_pid             (in_pid),
    .in_logical_address (in_logical_address),
    .lg                 (lg_r),
    .q_valid            (q_valid),
    .q_item             (q_item),
    .q_pop              (q_pop)
  );

  pfm_back u_back (
    .clk                  (clk),
    .rst_n                (rst_n),
    .q_valid              (q_valid),
    .q_item               (q_item),
    .q_pop                (q_pop),
    .policy               (policy_r),
    .lg                   (lg_r),
    .frames_in_use        (frames_r),
    .out_valid            (out_valid),
    .out_ready            (out_ready),
    .out_physical_address (out_physical_address),
    .out_frame_index      (out_frame_index),
    .out_page_fault       (out_page_fault),
    .out_evicted          (out_evicted),
    .out_victim_pid       (out_victim_pid),
    .out_victim_page      (out_victim_page),
    .out_released_count   (out_released_count),
    .status               (status)
  );

  a_evict_fault: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_evicted |-> out_page_fault)
    else $error("eviction without page fault");

  a_order_resident: assert property (@(posedge clk) disable iff (!rst_n)
    status.idle |-> status.order_cnt == status.resident_cnt)
    else $error("replacement order out of step with resident frames");

  a_release_clean: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_released_count != 9'd0 |-> !out_page_fault && !out_evicted)
    else $error("release beat carries access fields");

endmodule

// ----- tb/sv/paged_frame_manager_fifo_lru_tb.sv -----
// ----------------------------------------------------------------------------
// paged_frame_manager_fifo_lru_tb
// drives access and release beats through the frame manager under several
// policy, page size and frame count settings with random idling on both
// channels, and checks every result beat against a frame table tracker
// ----------------------------------------------------------------------------
module paged_frame_manager_fifo_lru_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import pfm_pkg::*;

  localparam int NF        = NUM_FRAMES;
  localparam int CYC_LIMIT = 2000000;
  localparam int DRAIN_CYC = 2 * NF + 8;

  typedef struct {
    logic        func;
    logic [7:0]  pid;
    logic [31:0] addr;
  } access_t;

  typedef struct {
    logic [23:0] phys;
    logic [7:0]  frame;
    logic        fault;
    logic        evict;
    logic [7:0]  vpid;
    logic [27:0] vpage;
    logic [8:0]  released;
  } xlate_t;

  logic        clk, rst_n;
  logic        cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_W-1:0]     cfg_data;
  logic        in_valid, in_ready, in_func;
  logic [7:0]  in_pid;
  logic [31:0] in_logical_address;
  logic        out_valid, out_ready;
  logic [23:0] out_physical_address;
  logic [7:0]  out_frame_index;
  logic        out_page_fault, out_evicted;
  logic [7:0]  out_victim_pid;
  logic [27:0] out_victim_page;
  logic [8:0]  out_released_count;

  paged_frame_manager_fifo_lru dut (.*);

  // tracker state
  logic        t_policy;
  logic [4:0]  t_lg;
  logic [8:0]  t_frames;
  logic        t_valid [NF];
  logic [7:0]  t_owner [NF];
  logic [27:0] t_page  [NF];
  int          t_order [NF];
  int          t_count;

  access_t pending_q[$];
  xlate_t  xlate_q[$];
  access_t cur;
  int      errors, cycles, in_gap, out_stall;
  bit      burst;

  initial begin
    clk = 0;
    forever #1 clk = ~clk;
  end

  function automatic int eff_lg();
    if (t_lg < LG_MIN) return LG_MIN;
    if (t_lg > LG_MAX) return LG_MAX;
    return t_lg;
  endfunction

  function automatic int eff_frames();
    if (t_frames == 0) return 1;
    if (t_frames > NF) return NF;
    return t_frames;
  endfunction

  function automatic void order_drop(int fr);
    int w;
    w = 0;
    for (int r = 0; r < t_count; r++)
      if (t_order[r] != fr) begin
        t_order[w] = t_order[r];
        w++;
      end
    t_count = w;
  endfunction

  function automatic void order_push(int fr);
    if (t_count < NF) begin
      t_order[t_count] = fr;
      t_count++;
    end
  endfunction

  function automatic xlate_t translate(access_t a);
    xlate_t x;
    int lg, lim, fr;
    logic [31:0] page, offs;
    bit hit, found;
    x = '{default: '0};
    lg = eff_lg();
    lim = eff_frames();
    fr = 0;
    hit = 0;
    found = 0;
    if (a.func == FUNC_RELEASE) begin
      for (int f = 0; f < NF; f++)
        if (t_valid[f] && t_owner[f] == a.pid) begin
          t_valid[f] = 0;
          order_drop(f);
          x.released++;
        end
      return x;
    end
    page = a.addr >> lg;
    offs = a.addr & ((32'd1 << lg) - 1);
    for (int f = 0; f < NF; f++)
      if (!hit && t_valid[f] && t_owner[f] == a.pid && t_page[f] == page[27:0]) begin
        fr = f;
        hit = 1;
      end
    if (hit) begin
      if (t_policy == POLICY_LRU) begin
        order_drop(fr);
        order_push(fr);
      end
    end else begin
      x.fault = 1;
      for (int f = 0; f < lim; f++)
        if (!found && !t_valid[f]) begin
          fr = f;
          found = 1;
        end
      if (!found && t_count > 0) begin
        fr = t_order[0];
        order_drop(fr);
        x.evict = 1;
        x.vpid = t_owner[fr];
        x.vpage = t_page[fr];
      end
      t_valid[fr] = 1;
      t_owner[fr] = a.pid;
      t_page[fr] = page[27:0];
      order_push(fr);
    end
    x.phys = 24'((32'(fr) << lg) + offs);
    x.frame = 8'(fr);
    return x;
  endfunction

  function automatic int pick_gap();
    int r;
    if (burst) return 0;
    r = $urandom_range(0, 99);
    if (r < 70) return 0;
    if (r < 95) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  task automatic mismatch(string what, longint got, longint want);
    $display("mismatch %s: got %0h want %0h", what, got, want);
    errors++;
  endtask

  // driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 0;
      in_gap = 0;
    end else begin
      if (in_valid && in_ready) xlate_q.push_back(translate(cur));
      if (!(in_valid && !in_ready)) begin
        if (in_gap > 0 || pending_q.size() == 0) begin
          if (in_gap > 0) in_gap--;
          in_valid <= 0;
        end else begin
          cur = pending_q.pop_front();
          in_func <= cur.func;
          in_pid <= cur.pid;
          in_logical_address <= cur.addr;
          in_valid <= 1;
          in_gap = pick_gap();
        end
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 0;
      out_stall = 0;
    end else begin
      if (out_valid && out_ready) begin
        if (xlate_q.size() == 0) mismatch("unexpected beat", 0, 0);
        else begin
          xlate_t w;
          w = xlate_q.pop_front();
          if (out_physical_address !== w.phys)
            mismatch("physical_address", out_physical_address, w.phys);
          if (out_frame_index !== w.frame) mismatch("frame_index", out_frame_index, w.frame);
          if (out_page_fault !== w.fault) mismatch("page_fault", out_page_fault, w.fault);
          if (out_evicted !== w.evict) mismatch("evicted", out_evicted, w.evict);
          if (out_victim_pid !== w.vpid) mismatch("victim_pid", out_victim_pid, w.vpid);
          if (out_victim_page !== w.vpage) mismatch("victim_page", out_victim_page, w.vpage);
          if (out_released_count !== w.released)
            mismatch("released_count", out_released_count, w.released);
        end
      end
      if (out_stall > 0) begin
        out_stall--;
        out_ready <= 0;
      end else begin
        out_ready <= 1;
        out_stall = pick_gap();
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYC_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  task automatic add(logic f, logic [7:0] p, logic [31:0] a);
    pending_q.push_back('{func: f, pid: p, addr: a});
  endtask

  task automatic add_random();
    int r, lg;
    logic [31:0] a;
    logic [7:0] p;
    r = $urandom_range(0, 99);
    lg = eff_lg();
    p = ($urandom_range(0, 9) == 0) ? 8'($urandom) : 8'($urandom_range(0, 3));
    if ($urandom_range(0, 9) == 0) a = $urandom;
    else a = (32'($urandom_range(0, 2 * NF)) << lg) | ($urandom & ((32'd1 << lg) - 1));
    if (r < 6) add(FUNC_RELEASE, p, $urandom);
    else add(FUNC_ACCESS, p, a);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
    @(posedge clk);
    cfg_we <= 1;
    cfg_index <= idx;
    cfg_data <= val;
    case (idx)
      CFG_POLICY:    t_policy = val[0];
      CFG_PAGE_LOG2: t_lg = val[4:0];
      default:       t_frames = val;
    endcase
    @(posedge clk);
    cfg_we <= 0;
  endtask

  task automatic drain();
    while (pending_q.size() != 0 || in_valid || xlate_q.size() != 0) @(negedge clk);
    repeat (DRAIN_CYC) @(posedge clk);
  endtask

  task automatic phase(logic pol, logic [4:0] lg, logic [8:0] nfr, int n);
    write_reg(CFG_POLICY, CFG_W'(pol));
    write_reg(CFG_PAGE_LOG2, CFG_W'(lg));
    write_reg(CFG_FRAMES, nfr);
    burst = ($urandom_range(0, 3) == 0);
    for (int i = 0; i < n; i++) add_random();
    drain();
  endtask

  initial begin
    errors = 0;
    cycles = 0;
    burst = 0;
    rst_n = 0;
    cfg_we = 0;
    cfg_index = '0;
    cfg_data = '0;
    in_valid = 0;
    in_func = 0;
    in_pid = 0;
    in_logical_address = 0;
    out_ready = 0;
    t_policy = POLICY_FIFO;
    t_lg = LG_RESET;
    t_frames = FRAMES_RESET;
    t_count = 0;
    for (int f = 0; f < NF; f++) begin
      t_valid[f] = 0;
      t_owner[f] = 0;
      t_page[f] = 0;
      t_order[f] = 0;
    end
    repeat (8) @(posedge clk);
    rst_n <= 1;

    // directed: extremes, hit, release of nothing, fill and evict
    add(FUNC_ACCESS, 8'd0, 32'h0);
    add(FUNC_ACCESS, 8'd0, 32'h0000_00ff);
    add(FUNC_ACCESS, 8'hff, 32'hffff_ffff);
    add(FUNC_RELEASE, 8'd7, 32'hffff_ffff);
    add(FUNC_RELEASE, 8'd0, 32'h0);
    for (int i = 0; i < NF + 2; i++) add(FUNC_ACCESS, 8'd1, 32'(i) << 8 | 32'h5a);
    add(FUNC_ACCESS, 8'hff, 32'hffff_ffff);
    add(FUNC_RELEASE, 8'd1, 32'h0);
    drain();

    phase(POLICY_LRU, 5'd4, 9'd16, 250);
    phase(POLICY_FIFO, 5'd16, 9'd4, 250);
    phase(POLICY_LRU, 5'd0, 9'd1, 200);
    phase(POLICY_FIFO, 5'd31, 9'd0, 200);
    phase(POLICY_LRU, 5'd12, 9'd256, 250);
    phase(POLICY_FIFO, 5'd6, 9'd17, 250);
    phase(POLICY_LRU, 5'd8, 9'd3, 250);
    phase(POLICY_FIFO, 5'd10, 9'd9, 250);

    if (errors == 0) $display("Test completed successfully");
    else $display("Test completed with failures");
    $finish;
  end
endmodule
